// File: hw/rtl/bol_pkg.sv
// Shared types and codes for the bounded ordered list.
`default_nettype none

package bol_pkg;

  // Command codes carried in the opcode field.
  localparam logic [2:0] OP_PUSH_FRONT   = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK    = 3'd1;
  localparam logic [2:0] OP_INSERT_AFTER = 3'd2;
  localparam logic [2:0] OP_POP_FRONT    = 3'd3;
  localparam logic [2:0] OP_POP_BACK     = 3'd4;

  // Status codes returned with every result.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_BADPOS = 2'd3;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] value;
    logic [3:0]         position;
  } bol_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] removed_value;
    logic [4:0]         entry_count;
  } bol_out_t;

endpackage

`default_nettype wire

// File: hw/rtl/bol_cell.sv
// One storage cell of the list: holds a single entry and shifts with its neighbors.
`default_nettype none

module bol_cell
  import bol_pkg::*;
#(
  parameter int IDX_W = 4,
  parameter int IDX   = 0
) (
  input  wire logic               clk,
  input  wire logic               ins_en,
  input  wire logic [IDX_W-1:0]   ins_at,
  input  wire logic               shift_dn,
  input  wire logic [IDX_W-1:0]   tail_idx,
  input  wire logic signed [31:0] ins_value,
  input  wire logic signed [31:0] prev_q,
  input  wire logic signed [31:0] next_q,
  output logic signed [31:0]      data_q,
  output logic signed [31:0]      tail_q
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic signed [31:0] data_r;
  logic signed [31:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ins_en) begin
      // Cells past the gap take their left neighbor; the gap cell loads the new value.
      if (MY_IDX == ins_at) begin
        data_nxt = ins_value;
      end else if (MY_IDX > ins_at) begin
        data_nxt = prev_q;
      end
    end else if (shift_dn) begin
      data_nxt = next_q;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q = data_r;
  // Only the tail cell drives its value, so the top can OR all taps together.
  assign tail_q = (MY_IDX == tail_idx) ? data_r : '0;

endmodule

`default_nettype wire

// File: hw/rtl/bounded_ordered_list.sv
// Top level of the bounded ordered list: command decode, count and a row of cells.
//
// Usage: commands arrive as beats on the in_ channel (valid/ready) and each
// command produces exactly one result beat on the out_ channel. A command can
// push at the front, push at the back, insert after a position, pop the front
// or pop the back. The result carries a status, the popped value (zero when
// nothing was popped) and the entry count after the command.
// The entries live in a row of CAPACITY cells; an insert shifts the cells
// past the insertion point away from the front and a front pop shifts every
// cell toward it in the same cycle, so each command finishes in the cycle it
// is accepted. The result appears in the output register in the cycle after
// acceptance, and a new command is taken in every cycle while the receiver
// keeps out_ready high: one command per cycle, set by the row update.
// When the receiver stalls, the result holds in the output register and
// in_ready drops until that beat is taken.
// Reset empties the list and clears the output valid; entry contents are not
// cleared and are never read before they are written.
`default_nettype none

module bounded_ordered_list
  import bol_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire bol_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output bol_out_t      out_data
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

  logic             in_fire;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             out_valid_r;
  bol_out_t         out_data_r;
  bol_out_t         result;

  logic             do_ins;
  logic             do_pop_front;
  logic             ins_en;
  logic             shift_dn;
  logic [IDX_W-1:0] ins_at;
  logic [IDX_W-1:0] tail_idx;
  logic             is_full;
  logic             is_empty;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] cnt_ext;

  logic signed [31:0] cell_q [CAPACITY];
  logic signed [31:0] tail_tap [CAPACITY];
  logic signed [31:0] tail_value;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign is_full  = (cnt_r == CNT_FULL);
  assign is_empty = (cnt_r == '0);
  assign tail_idx = IDX_W'(cnt_r - CNT_W'(1));
  assign pos_ext  = CMP_W'(in_data.position);
  assign cnt_ext  = CMP_W'(cnt_r);

  always_comb begin
    tail_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      tail_value = tail_value | tail_tap[i];
    end
  end

  always_comb begin
    result.status        = ST_OK;
    result.removed_value = '0;
    cnt_nxt              = cnt_r;
    do_ins               = 1'b0;
    do_pop_front         = 1'b0;
    ins_at               = '0;
    case (in_data.opcode)
      OP_PUSH_FRONT: begin
        if (is_full) begin
          result.status = ST_FULL;
        end else begin
          do_ins = 1'b1;
          ins_at = '0;
        end
      end
      OP_PUSH_BACK: begin
        if (is_full) begin
          result.status = ST_FULL;
        end else begin
          do_ins = 1'b1;
          ins_at = IDX_W'(cnt_r);
        end
      end
      OP_INSERT_AFTER: begin
        // The full check wins over the position check.
        if (is_full) begin
          result.status = ST_FULL;
        end else if (pos_ext >= cnt_ext) begin
          result.status = ST_BADPOS;
        end else begin
          do_ins = 1'b1;
          ins_at = IDX_W'(pos_ext + CMP_W'(1));
        end
      end
      OP_POP_FRONT: begin
        if (is_empty) begin
          result.status = ST_EMPTY;
        end else begin
          do_pop_front         = 1'b1;
          result.removed_value = cell_q[0];
          cnt_nxt              = cnt_r - CNT_W'(1);
        end
      end
      OP_POP_BACK: begin
        if (is_empty) begin
          result.status = ST_EMPTY;
        end else begin
          result.removed_value = tail_value;
          cnt_nxt              = cnt_r - CNT_W'(1);
        end
      end
      default: begin
        result.status = ST_OK;
      end
    endcase
    if (do_ins) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end
    result.entry_count = 5'(cnt_nxt);
  end

  assign ins_en   = in_fire && do_ins;
  assign shift_dn = in_fire && do_pop_front;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [31:0] prev_q;
    logic signed [31:0] next_q;
    if (g == 0) begin : g_first
      assign prev_q = '0;
    end else begin : g_mid_prev
      assign prev_q = cell_q[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign next_q = '0;
    end else begin : g_mid_next
      assign next_q = cell_q[g+1];
    end
    bol_cell #(
      .IDX_W (IDX_W),
      .IDX   (g)
    ) u_cell (
      .clk       (clk),
      .ins_en    (ins_en),
      .ins_at    (ins_at),
      .shift_dn  (shift_dn),
      .tail_idx  (tail_idx),
      .ins_value (in_data.value),
      .prev_q    (prev_q),
      .next_q    (next_q),
      .data_q    (cell_q[g]),
      .tail_q    (tail_tap[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The count never passes the capacity.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_FULL)
    else $error("entry count above capacity");

  // The count moves only when a command is accepted.
  a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_fire |=> $stable(cnt_r))
    else $error("entry count changed without a command");

  // A pop on an empty list reports empty and returns zero.
  a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && is_empty &&
     (in_data.opcode == OP_POP_FRONT || in_data.opcode == OP_POP_BACK))
    |=> (out_data_r.status == ST_EMPTY && out_data_r.removed_value == '0))
    else $error("pop on empty list not reported as empty");

  // A full status is only shown while the list actually holds capacity entries.
  a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status == ST_FULL) |-> (cnt_r == CNT_FULL))
    else $error("full status with list not full");

endmodule

`default_nettype wire
